// File: rtl/core/chained_range_remap_unit_assert.svh
// assertion macros for the chained range remap unit
`ifndef CHAINED_RANGE_REMAP_UNIT_ASSERT_SVH
`define CHAINED_RANGE_REMAP_UNIT_ASSERT_SVH

// implication checked at every rising clock edge outside reset
`define CRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define CRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/crr_pkg.sv
// package: types and constants of the chained range remap unit
package crr_pkg;

    localparam int unsigned FIELD_W = 40;

    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_CLEAR     = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_NONE      = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         stage_index;
        logic [4:0]         entry_index;
        logic [FIELD_W-1:0] source_start;
        logic [FIELD_W-1:0] dest_start;
        logic [FIELD_W-1:0] span_length;
        logic [FIELD_W-1:0] query_value;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] mapped_value;
        logic [FIELD_W-1:0] minimum_so_far;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_MIN,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic load;
        logic clear;
        logic scan;
        logic apply;
        logic next_stage;
        logic min_upd;
        logic out_set;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_load;
        logic is_clear;
        logic is_translate;
        logic scan_last;
        logic stage_last;
    } t_status;

endpackage

// File: rtl/core/crr_datapath.sv
// datapath: entry memories, stage scan, rebasing and running minimum
module crr_datapath #(
    parameter int unsigned STAGES            = 7,
    parameter int unsigned ENTRIES_PER_STAGE = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  crr_pkg::t_in_item i_item,
    input  logic [2:0]        i_active_stages,
    input  crr_pkg::t_cmd     i_cmd,
    output crr_pkg::t_status  o_status,
    output crr_pkg::t_out_item o_result
);
    import crr_pkg::*;

    localparam int unsigned TOTAL = STAGES * ENTRIES_PER_STAGE;
    localparam int unsigned SW = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int unsigned EW = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
    localparam int unsigned AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int unsigned CW = $clog2(STAGES + 1);
    localparam int unsigned VW = FIELD_W;

    logic [VW-1:0] r_src_mem [TOTAL];
    logic [VW-1:0] r_dst_mem [TOTAL];
    logic [VW-1:0] r_len_mem [TOTAL];
    logic [TOTAL-1:0] r_valid;

    logic [VW-1:0] r_src_rd, r_dst_rd, r_len_rd;
    logic          r_vld_rd;
    logic [1:0]    r_op;
    logic [2:0]    r_stage_in;
    logic [4:0]    r_entry_in;
    logic [VW-1:0] r_s_in, r_d_in, r_l_in;
    logic [VW-1:0] r_value, r_min, r_mapped;
    logic [SW-1:0] r_stage;
    logic [EW-1:0] r_entry;
    logic          r_hit;
    logic [CW-1:0] r_n_stages;

    logic [AW-1:0] n_waddr, n_raddr;
    logic          n_load_ok;
    logic [VW-1:0] n_diff;
    logic          n_match;
    logic [CW-1:0] n_sat;

    always_comb begin
        n_load_ok = (32'(r_stage_in) < STAGES) && (32'(r_entry_in) < ENTRIES_PER_STAGE);
        n_waddr   = AW'(32'(r_stage_in) * ENTRIES_PER_STAGE + 32'(r_entry_in));
        n_raddr   = AW'(32'(r_stage) * ENTRIES_PER_STAGE + 32'(r_entry));
        n_diff    = r_value - r_src_rd;
        n_match   = r_vld_rd && (r_value >= r_src_rd) && (n_diff < r_len_rd);
        n_sat     = (32'(i_active_stages) > STAGES) ? CW'(STAGES) : CW'(i_active_stages);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && n_load_ok) begin
            r_src_mem[n_waddr] <= r_s_in;
            r_dst_mem[n_waddr] <= r_d_in;
            r_len_mem[n_waddr] <= r_l_in;
        end
        r_src_rd <= r_src_mem[n_raddr];
        r_dst_rd <= r_dst_mem[n_raddr];
        r_len_rd <= r_len_mem[n_raddr];
        r_vld_rd <= r_valid[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_min   <= '1;
            r_op    <= OP_NONE;
            r_stage <= '0;
            r_entry <= '0;
            r_hit   <= 1'b0;
            r_n_stages <= '0;
        end else begin
            if (i_cmd.take) begin
                r_op       <= i_item.opcode;
                r_stage_in <= i_item.stage_index;
                r_entry_in <= i_item.entry_index;
                r_s_in     <= VW'(i_item.source_start);
                r_d_in     <= VW'(i_item.dest_start);
                r_l_in     <= VW'(i_item.span_length);
                r_value    <= VW'(i_item.query_value);
                r_stage    <= '0;
                r_entry    <= '0;
                r_hit      <= 1'b0;
                r_n_stages <= n_sat;
            end
            if (i_cmd.load && n_load_ok) begin
                r_valid[n_waddr] <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_valid <= '0;
                r_min   <= '1;
            end
            if (i_cmd.scan) begin
                // read of entry r_entry issued; compare the one read last cycle
                r_entry <= r_entry + EW'(1);
            end
            if (i_cmd.apply && !r_hit && n_match) begin
                r_value <= r_dst_rd + n_diff;
            end
            if (i_cmd.next_stage) begin
                r_stage <= r_stage + SW'(1);
                r_entry <= '0;
                r_hit   <= 1'b0;
            end else if (i_cmd.apply && !r_hit && n_match) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.min_upd && r_op == OP_TRANSLATE && r_value < r_min) begin
                r_min <= r_value;
            end
            if (i_cmd.out_set) begin
                r_mapped <= (r_op == OP_TRANSLATE) ? r_value : '0;
            end
        end
    end

    always_comb begin
        o_status.is_load      = (r_op == OP_LOAD);
        o_status.is_clear     = (r_op == OP_CLEAR);
        o_status.is_translate = (r_op == OP_TRANSLATE) && (r_n_stages != '0);
        o_status.scan_last    = (32'(r_entry) == ENTRIES_PER_STAGE - 1);
        o_status.stage_last   = (32'(r_stage) + 1 >= 32'(r_n_stages));
        o_result.mapped_value   = FIELD_W'(r_mapped);
        o_result.minimum_so_far = FIELD_W'(r_min);
    end
endmodule

// File: rtl/core/crr_ctrl.sv
// controller: sequences load, clear and the stage scan of a translate
module crr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  crr_pkg::t_status i_status,
    output crr_pkg::t_cmd    o_cmd
);
    import crr_pkg::*;

    t_state r_state, n_state;
    logic   r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_last      = 1'b0;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_APPLY;
                end
            end
            ST_APPLY: begin
                // decode the captured item
                if (i_status.is_load) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MIN;
                end else if (i_status.is_clear) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_MIN;
                end else if (i_status.is_translate) begin
                    o_cmd.scan = 1'b1;
                    n_last     = i_status.scan_last;
                    n_state    = ST_SCAN;
                end else begin
                    n_state = ST_MIN;
                end
            end
            ST_SCAN: begin
                o_cmd.apply = 1'b1;
                if (r_last) begin
                    if (i_status.stage_last) begin
                        n_state = ST_MIN;
                    end else begin
                        o_cmd.next_stage = 1'b1;
                        n_state          = ST_APPLY;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                    n_last     = i_status.scan_last;
                end
            end
            ST_MIN: begin
                o_cmd.min_upd = 1'b1;
                o_cmd.out_set = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// File: rtl/core/chained_range_remap_unit.sv
// top level of the chained range remap unit
// Each item takes one transfer in and gives one result. Load, clear, unused
// opcodes and a translate with zero active stages pass through the APPLY and
// MIN states and offer their result in OUT. A translate walks the entry table
// one entry a cycle through a registered memory read, visiting each active
// stage in turn before MIN and OUT. One item is in work at a time; the next
// is taken in the cycle after the result transfer at the earliest. The
// active_stages register (reset 7, values above STAGES act as STAGES) may be
// written only while the block is idle.
module chained_range_remap_unit #(
    parameter int unsigned STAGES            = 7,
    parameter int unsigned ENTRIES_PER_STAGE = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  crr_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output crr_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_data
);
    import crr_pkg::*;

    logic [2:0] r_active_stages;
    t_cmd       cmd;
    t_status    status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_stages <= 3'd7;
        end else if (i_cfg_valid) begin
            r_active_stages <= i_cfg_data;
        end
    end

    crr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    crr_datapath #(
        .STAGES            (STAGES),
        .ENTRIES_PER_STAGE (ENTRIES_PER_STAGE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_in_data),
        .i_active_stages (r_active_stages),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_result        (o_out_data)
    );
endmodule

// File: rtl/core/crr_checker.sv
// port-level checker for the chained range remap unit
`include "chained_range_remap_unit_assert.svh"
module crr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input crr_pkg::t_out_item o_out_data
);
    `CRR_ASSERT_IMP(a_one_side, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `CRR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data))
    `CRR_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready && !o_out_valid)
    `CRR_ASSERT_IMP(a_min_bound, i_clk, i_rst_n, o_out_valid,
        o_out_data.mapped_value == '0 ||
        o_out_data.minimum_so_far <= o_out_data.mapped_value)
endmodule

bind chained_range_remap_unit crr_checker u_crr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: tb/tb_chained_range_remap_unit.sv
// testbench for the chained range remap unit: queued stimulus, scoreboard against a local model
`timescale 1ns / 100ps

module tb_chained_range_remap_unit;
    import crr_pkg::*;

    localparam int unsigned NSTG = 7;
    localparam int unsigned NENT = 32;
    localparam logic [39:0] ALL_ONES = '1;
    localparam int unsigned WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in_item i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out_item o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [2:0] i_cfg_data;

    chained_range_remap_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    logic [39:0] tbl_src [NSTG*NENT];
    logic [39:0] tbl_dst [NSTG*NENT];
    logic [39:0] tbl_len [NSTG*NENT];
    logic        tbl_vld [NSTG*NENT];
    logic [39:0] min_model;
    logic [2:0]  stage_count;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int unsigned errors;
    bit idle_on;
    bit sender_pause;
    int unsigned hold_cycles;
    int unsigned quiet_cycles;

    function automatic t_out_item predict_remap(t_in_item it);
        t_out_item r;
        logic [39:0] v;
        int unsigned n;
        int unsigned k;
        bit hit;
        r.mapped_value = '0;
        case (it.opcode)
            OP_LOAD: begin
                if (it.stage_index < NSTG) begin
                    k = it.stage_index * NENT + it.entry_index;
                    tbl_src[k] = it.source_start;
                    tbl_dst[k] = it.dest_start;
                    tbl_len[k] = it.span_length;
                    tbl_vld[k] = 1'b1;
                end
            end
            OP_CLEAR: begin
                foreach (tbl_vld[i]) tbl_vld[i] = 1'b0;
                min_model = ALL_ONES;
            end
            OP_TRANSLATE: begin
                n = (stage_count > NSTG) ? NSTG : stage_count;
                v = it.query_value;
                for (int s = 0; s < n; s++) begin
                    hit = 0;
                    for (int e = 0; e < NENT && !hit; e++) begin
                        k = s * NENT + e;
                        if (tbl_vld[k] && v >= tbl_src[k] && (v - tbl_src[k]) < tbl_len[k]) begin
                            v = tbl_dst[k] + (v - tbl_src[k]);
                            hit = 1;
                        end
                    end
                end
                r.mapped_value = v;
                if (v < min_model) min_model = v;
            end
            default: ;
        endcase
        r.minimum_so_far = min_model;
        return r;
    endfunction

    function automatic logic [39:0] rand40();
        logic [39:0] x;
        case ($urandom_range(0, 5))
            0: x = '0;
            1: x = ALL_ONES;
            2: x = 40'($urandom_range(0, 400));
            default: x = 40'({$urandom(), $urandom()});
        endcase
        return x;
    endfunction

    function automatic t_in_item make_item(logic [1:0] op);
        t_in_item it;
        it.opcode = op;
        it.stage_index = 3'($urandom_range(0, 7));
        it.entry_index = 5'($urandom());
        it.source_start = rand40();
        it.dest_start = rand40();
        it.span_length = rand40();
        it.query_value = rand40();
        return it;
    endfunction

    // well-formed chain: small intervals that overlap query values
    function automatic t_in_item make_chain_load();
        t_in_item it;
        it = make_item(OP_LOAD);
        it.stage_index = 3'($urandom_range(0, 6));
        it.entry_index = 5'($urandom_range(0, 7));
        it.source_start = 40'($urandom_range(0, 300));
        it.dest_start = 40'($urandom_range(0, 300));
        it.span_length = 40'($urandom_range(0, 120));
        return it;
    endfunction

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            i_in_data <= '0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_items.size() > 0 && !sender_pause &&
                (!idle_on || $urandom_range(0, 99) >= 37)) begin
                i_in_data <= pending_items[0];
                i_in_valid <= 1;
                expected_results.insert(expected_results.size(),
                                        predict_remap(pending_items.pop_front()));
            end else begin
                i_in_valid <= 0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= !idle_on || $urandom_range(0, 99) >= 37;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.mapped_value !== want.mapped_value) begin
                    $error("mapped_value expected %h got %h",
                           want.mapped_value, o_out_data.mapped_value);
                    errors++;
                end
                if (o_out_data.minimum_so_far !== want.minimum_so_far) begin
                    $error("minimum_so_far expected %h got %h",
                           want.minimum_so_far, o_out_data.minimum_so_far);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_stages(logic [2:0] val);
        i_cfg_data <= val;
        i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        stage_count = val;
        @(posedge i_clk);
    endtask

    task automatic queue_random(int unsigned count);
        int unsigned r;
        t_in_item it;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 45) it = make_chain_load();
            else if (r < 85) begin
                it = make_item(OP_TRANSLATE);
                if ($urandom_range(0, 3) != 0) it.query_value = 40'($urandom_range(0, 400));
            end else if (r < 90) it = make_item(OP_CLEAR);
            else if (r < 95) it = make_item(OP_NONE);
            else it = make_item(OP_LOAD);
            pending_items.insert(pending_items.size(), it);
        end
    endtask

    initial begin
        t_in_item it;
        logic [2:0] settings [6];
        settings = '{3'd0, 3'd1, 3'd7, 3'd3, 3'd5, 3'd6};
        errors = 0;
        idle_on = 1;
        sender_pause = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        foreach (tbl_vld[i]) tbl_vld[i] = 0;
        min_model = ALL_ONES;
        stage_count = 3'd7;
        i_cfg_valid = 0;
        i_cfg_data = '0;
        i_in_valid = 0;
        i_in_data = '0;
        i_out_ready = 0;
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, every opcode, containment edges, out of range loads
        it = make_item(OP_TRANSLATE); it.query_value = ALL_ONES;
        pending_items.insert(pending_items.size(), it);
        it = make_item(OP_LOAD); it.stage_index = 3'd0; it.entry_index = 5'd31;
        it.source_start = 40'd100; it.dest_start = ALL_ONES; it.span_length = 40'd10;
        pending_items.insert(pending_items.size(), it);
        it = make_item(OP_LOAD); it.stage_index = 3'd0; it.entry_index = 5'd0;
        it.source_start = 40'd100; it.dest_start = 40'd5; it.span_length = 40'd0;
        pending_items.insert(pending_items.size(), it);
        for (int q = 98; q <= 111; q += 1) begin
            if (q == 98 || q == 99 || q == 100 || q == 101 || q == 109 || q == 110) begin
                it = make_item(OP_TRANSLATE); it.query_value = 40'(q);
                pending_items.insert(pending_items.size(), it);
            end
        end
        it = make_item(OP_LOAD); it.stage_index = 3'd7; it.entry_index = 5'd3;
        pending_items.insert(pending_items.size(), it);
        it = make_item(OP_LOAD); it.stage_index = 3'd6; it.entry_index = 5'd0;
        it.source_start = ALL_ONES; it.dest_start = 40'd0; it.span_length = ALL_ONES;
        pending_items.insert(pending_items.size(), it);
        it = make_item(OP_TRANSLATE); it.query_value = ALL_ONES;
        pending_items.insert(pending_items.size(), it);
        it = make_item(OP_TRANSLATE); it.query_value = 40'd0;
        pending_items.insert(pending_items.size(), it);
        it = make_item(OP_NONE);
        pending_items.insert(pending_items.size(), it);
        it = make_item(OP_CLEAR);
        pending_items.insert(pending_items.size(), it);
        it = make_item(OP_TRANSLATE); it.query_value = 40'd105;
        pending_items.insert(pending_items.size(), it);
        it = make_item(OP_NONE); it.stage_index = '1; it.entry_index = '1;
        it.source_start = '1; it.dest_start = '1; it.span_length = '1;
        pending_items.insert(pending_items.size(), it);
        wait_drained();

        // random phases across register settings
        foreach (settings[i]) begin
            write_stages(settings[i]);
            if (i == 2) begin
                hold_cycles = 600;
                queue_random(40);
            end
            idle_on = (i != 3);
            queue_random(200);
            if (i == 4) begin
                while (pending_items.size() > 100) @(posedge i_clk);
                sender_pause = 1;
                while (i_in_valid || expected_results.size() > 0) @(posedge i_clk);
                sender_pause = 0;
            end
            wait_drained();
        end
        write_stages(3'd7);
        idle_on = 1;
        queue_random(60);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
